// File: src/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the bank switch mapper.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned PrgSlots = 3;
  localparam int unsigned ChrSlots = 8;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_PRG   = 2'd2,
    FUNC_CHR   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  localparam logic [3:0] GRP_PRG   = 4'h8;
  localparam logic [3:0] GRP_PRG2  = 4'h9;
  localparam logic [3:0] GRP_CHR_A = 4'hA;
  localparam logic [3:0] GRP_CHR_B = 4'hB;
  localparam logic [3:0] GRP_CHR_C = 4'hC;
  localparam logic [3:0] GRP_CHR_D = 4'hD;
  localparam logic [3:0] GRP_MISC  = 4'hE;
  localparam logic [3:0] GRP_IRQ   = 4'hF;

  localparam logic [1:0] PRG_FIXED_SLOT = 2'd3;
  localparam logic [7:0] IRQ_WRAP       = 8'hFF;
  localparam logic [8:0] BANK_MAX       = 9'd256;

  localparam logic [8:0] PRG_COUNT_RST = 9'd16;
  localparam logic [8:0] CHR_COUNT_RST = 9'd0;
  localparam logic [7:0] PRG_SEL_RST0  = 8'd0;
  localparam logic [7:0] PRG_SEL_RST1  = 8'd1;
  localparam logic [7:0] PRG_SEL_RST2  = 8'd254;

  localparam logic APB_REG_PRG = 1'b0;
  localparam logic APB_REG_CHR = 1'b1;

  typedef struct packed {
    logic        we;
    logic        tick;
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] sel;
    logic [1:0] mirror;
    logic       pulse;
  } rsp_t;

endpackage

// File: src/bsm_mod.sv
// ----------------------------------------------------------------------------
// bsm_mod
// Iterative restoring modulo: 8-bit dividend by 9-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module bsm_mod (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [8:0] divisor_i,
  output logic       done_o,
  output logic [7:0] result_o
);

  logic [8:0] rem_q, rem_d;
  logic [7:0] dvd_q, dvd_d;
  logic [8:0] div_q, div_d;
  logic [2:0] cnt_q, cnt_d;
  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [8:0] trial;

  always_comb begin
    trial  = {rem_q[7:0], dvd_q[7]};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = 3'd7;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (trial >= div_q) ? trial - div_q : trial;
      dvd_d = {dvd_q[6:0], 1'b0};
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o   = done_q;
  assign result_o = rem_q[7:0];

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("modulo done without a running division");

endmodule

// File: src/bsm_regs.sv
// ----------------------------------------------------------------------------
// bsm_regs
// Mapper register file: bank selects, mirroring and scanline IRQ counter.
// ----------------------------------------------------------------------------
module bsm_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bsm_pkg::cmd_t cmd_i,
  output bsm_pkg::rsp_t rsp_o
);

  logic [7:0] prg_q [bsm_pkg::PrgSlots];
  logic [7:0] chr_q [bsm_pkg::ChrSlots];
  logic [7:0] latch_q;
  logic [7:0] count_q;
  logic       enabled_q;
  logic       ack_q;
  logic       cycle_q;
  logic [1:0] mirror_q;

  logic [3:0] grp;
  logic       pair;
  logic [2:0] chr_idx;
  logic [1:0] prg_slot;
  logic       tick_live;

  assign grp       = cmd_i.addr[15:12];
  assign pair      = cmd_i.addr[3] | cmd_i.addr[4];
  assign chr_idx   = {2'(grp[1:0] - 2'd2), pair};
  assign prg_slot  = cmd_i.addr[14:13];
  assign tick_live = cmd_i.tick & enabled_q & ~cycle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_q[0]  <= bsm_pkg::PRG_SEL_RST0;
      prg_q[1]  <= bsm_pkg::PRG_SEL_RST1;
      prg_q[2]  <= bsm_pkg::PRG_SEL_RST2;
      for (int i = 0; i < bsm_pkg::ChrSlots; i++) begin
        chr_q[i] <= 8'(i);
      end
      latch_q   <= '0;
      count_q   <= '0;
      enabled_q <= 1'b0;
      ack_q     <= 1'b0;
      cycle_q   <= 1'b0;
      mirror_q  <= '0;
    end else if (cmd_i.we) begin
      unique case (grp)
        bsm_pkg::GRP_PRG: prg_q[pair] <= cmd_i.data;
        bsm_pkg::GRP_PRG2: begin
          if (!pair) prg_q[2] <= cmd_i.data;
        end
        bsm_pkg::GRP_CHR_A, bsm_pkg::GRP_CHR_B,
        bsm_pkg::GRP_CHR_C, bsm_pkg::GRP_CHR_D: chr_q[chr_idx] <= cmd_i.data;
        bsm_pkg::GRP_MISC: begin
          if (!pair) mirror_q <= cmd_i.data[1:0];
          else       latch_q  <= cmd_i.data;
        end
        bsm_pkg::GRP_IRQ: begin
          if (!pair) begin
            ack_q     <= cmd_i.data[0];
            enabled_q <= cmd_i.data[1];
            cycle_q   <= cmd_i.data[2];
            if (cmd_i.data[1]) count_q <= latch_q;
          end else begin
            enabled_q <= ack_q;
          end
        end
        default: ;
      endcase
    end else if (tick_live) begin
      count_q <= (count_q == bsm_pkg::IRQ_WRAP) ? latch_q : count_q + 8'd1;
    end
  end

  always_comb begin
    rsp_o.mirror = mirror_q;
    rsp_o.pulse  = tick_live & (count_q == bsm_pkg::IRQ_WRAP);
    if (cmd_i.func == bsm_pkg::FUNC_CHR) begin
      rsp_o.sel = chr_q[cmd_i.addr[12:10]];
    end else if (prg_slot == bsm_pkg::PRG_FIXED_SLOT) begin
      rsp_o.sel = '0;
    end else begin
      rsp_o.sel = prg_q[prg_slot];
    end
  end

endmodule

// File: src/bank_switch_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq
// Cartridge bank mapper with scanline IRQ counter and bank translation.
//
//   channel  dir  handshake               payload
//   s_axis   in   tvalid/tready           tdata: addr, data; tuser: func
//   m_axis   out  tvalid/tready           tdata: bank, irq_pulse, mirror_mode
//   apb      in   psel/penable/pready     prg_bank_count @0, chr_bank_count @4
//
// Writes and ticks pass the execute and done states into the result register;
// modulo translates wait in the divide state on the bit-serial unit (8 steps).
// One item at a time; tready is high only while the sequencer is idle.
// A full output register stalls the sequencer in its final state.
// Reset is asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_scanline_irq (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] addr, [23:16] data
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] bank, [8] irq_pulse, [10:9] mirror_mode
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bsm_pkg::state_e state_q, state_d;
  bsm_pkg::cmd_t   cmd;
  bsm_pkg::rsp_t   rsp;

  logic [1:0]  func_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic [7:0]  bank_q, bank_d;
  logic        pulse_q, pulse_d;
  logic [8:0]  prg_cnt_q, chr_cnt_q;
  logic [8:0]  prg_eff, chr_eff, divisor;
  logic        div_start, div_done;
  logic [7:0]  div_result;
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        accept, out_load, cfg_we;

  assign accept = s_axis_tvalid & s_axis_tready;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q <= bsm_pkg::PRG_COUNT_RST;
      chr_cnt_q <= bsm_pkg::CHR_COUNT_RST;
    end else if (cfg_we) begin
      if (paddr[2] == bsm_pkg::APB_REG_PRG) prg_cnt_q <= pwdata[8:0];
      else                                  chr_cnt_q <= pwdata[8:0];
    end
  end

  assign prdata = {23'd0, (paddr[2] == bsm_pkg::APB_REG_PRG) ? prg_cnt_q : chr_cnt_q};

  assign prg_eff = (prg_cnt_q == 9'd0 || prg_cnt_q > bsm_pkg::BANK_MAX)
                   ? bsm_pkg::BANK_MAX : prg_cnt_q;
  assign chr_eff = (chr_cnt_q > bsm_pkg::BANK_MAX) ? bsm_pkg::BANK_MAX : chr_cnt_q;
  assign divisor = (func_q == bsm_pkg::FUNC_CHR) ? chr_eff : prg_eff;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_axis_tuser;
      addr_q <= s_axis_tdata[15:0];
      data_q <= s_axis_tdata[23:16];
    end
    bank_q  <= bank_d;
    pulse_q <= pulse_d;
  end

  always_comb begin
    cmd.func = func_q;
    cmd.addr = addr_q;
    cmd.data = data_q;
    cmd.we   = (state_q == bsm_pkg::ST_EXEC) && (func_q == bsm_pkg::FUNC_WRITE)
               && addr_q[15];
    cmd.tick = (state_q == bsm_pkg::ST_EXEC) && (func_q == bsm_pkg::FUNC_TICK);
  end

  bsm_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  bsm_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rsp.sel),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .result_o   (div_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bsm_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d       = state_q;
    bank_d        = bank_q;
    pulse_d       = pulse_q;
    div_start     = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      bsm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = bsm_pkg::ST_EXEC;
      end
      bsm_pkg::ST_EXEC: begin
        bank_d  = '0;
        pulse_d = rsp.pulse;
        state_d = bsm_pkg::ST_DONE;
        unique case (func_q)
          bsm_pkg::FUNC_PRG: begin
            if (addr_q[15]) begin
              if (addr_q[14:13] == bsm_pkg::PRG_FIXED_SLOT) begin
                bank_d = 8'(prg_eff - 9'd1);
              end else begin
                div_start = 1'b1;
                state_d   = bsm_pkg::ST_DIV;
              end
            end
          end
          bsm_pkg::FUNC_CHR: begin
            if (chr_cnt_q == 9'd0) begin
              bank_d = rsp.sel;
            end else begin
              div_start = 1'b1;
              state_d   = bsm_pkg::ST_DIV;
            end
          end
          default: ;
        endcase
      end
      bsm_pkg::ST_DIV: begin
        if (div_done) begin
          bank_d  = div_result;
          state_d = bsm_pkg::ST_DONE;
        end
      end
      bsm_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = bsm_pkg::ST_IDLE;
        end
      end
      default: state_d = bsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= {5'd0, rsp.mirror, pulse_q, bank_q};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == bsm_pkg::ST_EXEC)
    else $error("transfer not followed by execute");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == bsm_pkg::ST_DIV)
    else $error("modulo result outside divide state");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == bsm_pkg::ST_IDLE)
    else $error("result load lost");

  a_pulse_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsm_pkg::ST_DONE && pulse_q) |-> func_q == bsm_pkg::FUNC_TICK)
    else $error("irq pulse on a non-tick item");

endmodule

// File: bench/bank_mapper_checker.sv
// ----------------------------------------------------------------------------
// bank_mapper_checker
// Watches the request, result and register ports of the bank switch mapper.
// It keeps its own copy of the bank selects, IRQ counter and bank counts,
// works out the result of every accepted request, and compares each returned
// result in order against the oldest outstanding one.
// ----------------------------------------------------------------------------
module bank_mapper_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] addr, [23:16] data
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] bank, [8] irq_pulse, [10:9] mirror_mode
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned due_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] mirror;
    logic       pulse;
    logic [7:0] bank;
  } mapper_out_t;

  localparam logic [15:0] AUDIO_MASK   = 16'hF030;
  localparam logic [15:0] AUDIO_PORT_A = 16'h9010;
  localparam logic [15:0] AUDIO_PORT_B = 16'h9030;
  localparam logic [15:0] PAIR_BITS    = 16'h0018;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [8:0]  prg_count;
  logic [8:0]  chr_count;
  logic [7:0]  prg_sel [bsm_pkg::PrgSlots];
  logic [7:0]  chr_sel [bsm_pkg::ChrSlots];
  logic [7:0]  irq_latch;
  logic [7:0]  irq_count;
  logic        irq_on;
  logic        irq_restore;
  logic        irq_cycle;
  logic [1:0]  mirror;
  mapper_out_t due_q [$];
  int unsigned errors;

  function automatic mapper_out_t map_request(bsm_pkg::func_e f, logic [15:0] a,
                                              logic [7:0] d);
    mapper_out_t r;
    logic [3:0]  grp;
    logic        pair;
    int unsigned n;
    int unsigned sel;
    r    = '0;
    grp  = a[15:12];
    pair = |(a & PAIR_BITS);
    case (f)
      bsm_pkg::FUNC_WRITE: begin
        if ((a & AUDIO_MASK) != AUDIO_PORT_A && (a & AUDIO_MASK) != AUDIO_PORT_B) begin
          case (grp)
            bsm_pkg::GRP_PRG: prg_sel[pair] = d;
            bsm_pkg::GRP_PRG2: begin
              if (!pair) prg_sel[2] = d;
            end
            bsm_pkg::GRP_CHR_A, bsm_pkg::GRP_CHR_B,
            bsm_pkg::GRP_CHR_C, bsm_pkg::GRP_CHR_D: begin
              chr_sel[((int'(grp) - int'(bsm_pkg::GRP_CHR_A)) * 2 + int'(pair))
                      % bsm_pkg::ChrSlots] = d;
            end
            bsm_pkg::GRP_MISC: begin
              if (!pair) mirror = d[1:0];
              else irq_latch = d;
            end
            bsm_pkg::GRP_IRQ: begin
              if (!pair) begin
                irq_restore = d[0];
                irq_on      = d[1];
                irq_cycle   = d[2];
                if (irq_on) irq_count = irq_latch;
              end else begin
                irq_on = irq_restore;
              end
            end
            default: ;
          endcase
        end
      end
      bsm_pkg::FUNC_TICK: begin
        if (irq_on && !irq_cycle) begin
          if (irq_count == bsm_pkg::IRQ_WRAP) begin
            irq_count = irq_latch;
            r.pulse   = 1'b1;
          end else begin
            irq_count++;
          end
        end
      end
      bsm_pkg::FUNC_PRG: begin
        if (a[15]) begin
          n = (prg_count == 0 || prg_count > bsm_pkg::BANK_MAX) ? bsm_pkg::BANK_MAX
                                                                : prg_count;
          if (a[14:13] == bsm_pkg::PRG_FIXED_SLOT) r.bank = 8'(n - 1);
          else r.bank = 8'(prg_sel[a[14:13]] % n);
        end
      end
      bsm_pkg::FUNC_CHR: begin
        sel = chr_sel[a[12:10]];
        n   = (chr_count > bsm_pkg::BANK_MAX) ? bsm_pkg::BANK_MAX : chr_count;
        r.bank = (n == 0) ? 8'(sel) : 8'(sel % n);
      end
      default: ;
    endcase
    r.mirror = mirror;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    mapper_out_t got;
    mapper_out_t want;
    if (!rst_ni) begin
      prg_count   = bsm_pkg::PRG_COUNT_RST;
      chr_count   = bsm_pkg::CHR_COUNT_RST;
      prg_sel[0]  = bsm_pkg::PRG_SEL_RST0;
      prg_sel[1]  = bsm_pkg::PRG_SEL_RST1;
      prg_sel[2]  = bsm_pkg::PRG_SEL_RST2;
      for (int i = 0; i < bsm_pkg::ChrSlots; i++) chr_sel[i] = 8'(i);
      irq_latch   = '0;
      irq_count   = '0;
      irq_on      = 1'b0;
      irq_restore = 1'b0;
      irq_cycle   = 1'b0;
      mirror      = '0;
      due_q.delete();
      errors      = 0;
      fail_count <= 0;
      due_count  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[10:0];
        if (due_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%t: result bank %0d pulse %0b mirror %0d with nothing outstanding",
                     $realtime, got.bank, got.pulse, got.mirror);
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display({"%t: expected bank %0d pulse %0b mirror %0d, ",
                        "got bank %0d pulse %0b mirror %0d"},
                       $realtime, want.bank, want.pulse, want.mirror,
                       got.bank, got.pulse, got.mirror);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_q.push_back(map_request(bsm_pkg::func_e'(s_axis_tuser), s_axis_tdata[15:0],
                                    s_axis_tdata[23:16]));
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == bsm_pkg::APB_REG_PRG) prg_count = pwdata[8:0];
        else chr_count = pwdata[8:0];
      end
      due_count  <= due_q.size();
      fail_count <= errors;
    end
  end

endmodule

// File: bench/tb_bank_switch_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// tb_bank_switch_mapper_with_scanline_irq
// Drives the bank switch mapper with directed and random CPU writes, scanline
// ticks and bank translations over a series of bank count settings, with
// random gaps on both stream sides. Checking is left to bank_mapper_checker.
// ----------------------------------------------------------------------------
module tb_bank_switch_mapper_with_scanline_irq;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned WAIT_MAX      = 18;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned MIX_QUOTA     = 140;
  localparam logic [8:0] PRG_PLAN [PHASES] = '{9'd2, 9'd256, 9'd1, 9'd0,
                                               9'd511, 9'd255, 9'd3, 9'd16};
  localparam logic [8:0] CHR_PLAN [PHASES] = '{9'd256, 9'd1, 9'd0, 9'd511,
                                               9'd257, 9'd255, 9'd100, 9'd0};

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [15:0] addr, [23:16] data
  logic [1:0]  s_tuser;   // [1:0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] bank, [8] irq_pulse, [10:9] mirror_mode
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned fail_count;
  int unsigned due_count;
  int unsigned issued;
  bit          calm;

  bank_switch_mapper_with_scanline_irq dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bank_mapper_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .due_count     (due_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  task automatic send(bsm_pkg::func_e f, logic [15:0] a, logic [7:0] d);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {d, a};
    s_tuser  <= f;
    do @(posedge clk_i); while (!s_tready);
    issued++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [8:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {23'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_mix(int unsigned quota);
    int unsigned goal;
    int unsigned pick;
    logic [15:0] a;
    logic [7:0]  d;
    goal = issued + quota;
    while (issued < goal) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) calm = ($urandom_range(0, 3) == 0);
      if (pick < 12) begin
        // load latch, arm counter, then run scanlines
        a = {bsm_pkg::GRP_MISC, 12'($urandom)};
        if (a[4:3] == 2'b00) a[3] = 1'b1;
        d = $urandom_range(0, 1) ? 8'($urandom_range(8'hE0, 8'hFF)) : 8'($urandom);
        send(bsm_pkg::FUNC_WRITE, a, d);
        a = {bsm_pkg::GRP_IRQ, 12'($urandom)};
        a[4:3] = 2'b00;
        d = 8'($urandom);
        d[1] = ($urandom_range(0, 7) != 0);
        d[2] = ($urandom_range(0, 7) == 0);
        send(bsm_pkg::FUNC_WRITE, a, d);
        repeat ($urandom_range(1, 12))
          send(bsm_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
      end else if (pick < 32) begin
        send(bsm_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
      end else if (pick < 50) begin
        send(bsm_pkg::FUNC_PRG, 16'($urandom), 8'($urandom));
      end else if (pick < 68) begin
        send(bsm_pkg::FUNC_CHR, 16'($urandom), 8'($urandom));
      end else if (pick < 95) begin
        send(bsm_pkg::FUNC_WRITE, {4'($urandom_range(8, 15)), 12'($urandom)},
             8'($urandom));
      end else if (pick < 98) begin
        send(bsm_pkg::FUNC_WRITE, 16'($urandom), 8'($urandom));
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = draw_wait();
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = bsm_pkg::FUNC_WRITE;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    issued   = 0;
    calm     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send(bsm_pkg::FUNC_TICK,  16'h0000, 8'h00);
    send(bsm_pkg::FUNC_PRG,   16'h0000, 8'h00);
    send(bsm_pkg::FUNC_PRG,   16'h7FFF, 8'hFF);
    send(bsm_pkg::FUNC_PRG,   16'h8000, 8'h00);
    send(bsm_pkg::FUNC_PRG,   16'hFFFF, 8'h00);
    send(bsm_pkg::FUNC_CHR,   16'h0000, 8'h00);
    send(bsm_pkg::FUNC_CHR,   16'hFFFF, 8'h00);
    send(bsm_pkg::FUNC_WRITE, 16'h8000, 8'hFF);
    send(bsm_pkg::FUNC_WRITE, 16'h8018, 8'h05);
    send(bsm_pkg::FUNC_WRITE, 16'h9010, 8'h33);
    send(bsm_pkg::FUNC_WRITE, 16'h9030, 8'h44);
    send(bsm_pkg::FUNC_WRITE, 16'h9008, 8'h55);
    send(bsm_pkg::FUNC_WRITE, 16'h9000, 8'h81);
    send(bsm_pkg::FUNC_WRITE, 16'h7FFF, 8'hAA);
    send(bsm_pkg::FUNC_PRG,   16'hA000, 8'h00);
    send(bsm_pkg::FUNC_PRG,   16'hDFFF, 8'h00);
    send(bsm_pkg::FUNC_WRITE, 16'hD018, 8'hFF);
    send(bsm_pkg::FUNC_CHR,   16'hFC00, 8'h00);
    send(bsm_pkg::FUNC_WRITE, 16'hE000, 8'h03);
    send(bsm_pkg::FUNC_WRITE, 16'hE010, 8'hFE);
    send(bsm_pkg::FUNC_WRITE, 16'hF000, 8'h02);
    send(bsm_pkg::FUNC_TICK,  16'h0000, 8'h00);
    send(bsm_pkg::FUNC_TICK,  16'h0000, 8'h00);
    send(bsm_pkg::FUNC_WRITE, 16'hF000, 8'h07);
    send(bsm_pkg::FUNC_TICK,  16'h0000, 8'h00);
    send(bsm_pkg::FUNC_WRITE, 16'hF008, 8'h00);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        cfg_write(bsm_pkg::APB_REG_PRG, 9'($urandom));
        cfg_write(bsm_pkg::APB_REG_CHR, 9'($urandom));
      end else begin
        cfg_write(bsm_pkg::APB_REG_PRG, PRG_PLAN[p]);
        cfg_write(bsm_pkg::APB_REG_CHR, CHR_PLAN[p]);
      end
      run_mix(MIX_QUOTA);
      drain_results();
    end

    if (fail_count == 0 && due_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
